@@ rtl/lifo_stack_with_search_macros.svh @@
// Assertion macros shared by the stack RTL.
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent check on the rising clock, held off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Concurrent check on the rising clock, also active during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/lss_pkg.sv @@
// Package with the sequencer states, mode codes and status codes of the stack.
`timescale 1ns / 1ps

package lss_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;

  typedef enum logic [1:0] {
    IDLE,
    POP_READ,
    WALK
  } lss_state_t;

  localparam logic [1:0] MODE_DISPLAY = 2'd0;
  localparam logic [1:0] MODE_PUSH    = 2'd1;
  localparam logic [1:0] MODE_POP     = 2'd2;
  localparam logic [1:0] MODE_SEARCH  = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;

endpackage

@@ rtl/lss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lifo_stack_with_search.sv @@
// Top level: bounded LIFO stack of 32-bit words with push, pop, search and display.
//
// Usage: drive mode and operand_value and raise start; the command is taken
// at a rising edge where start is high and busy is low. Results come out on
// status, result_value, position and last_of_run, each valid for exactly one
// cycle while done is high; the receiver cannot stall, so every word must be
// captured in that cycle. The final word of a command has last_of_run set.
// Push, pop of an empty stack, search of an empty stack and display of an
// empty stack answer in the cycle after the start edge and busy never
// rises, so such a command can follow every cycle. Pop first reads the top
// entry in POP_READ. Search walks down from the top and stops at the first
// hit or the bottom entry; display emits entry_count words on consecutive cycles.
// The walk is set by the single read port of the stack memory and the one
// shared 32-bit comparator: one entry is read and checked per cycle.
// Reset (rst, synchronous) empties the stack and drops any command in
// flight; memory contents are not cleared, and no entry is read before it
// is written.
`timescale 1ns / 1ps
`include "lifo_stack_with_search_macros.svh"

module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] operand_value,
  output logic                     done,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] result_value,
  output logic [POS_W-1:0]         position,
  output logic                     last_of_run
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  lss_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic [DATA_W-1:0] key, key_next;
  logic seek, seek_next;

  logic done_next;
  logic [2:0] status_next;
  logic [DATA_W-1:0] result_value_next;
  logic [POS_W-1:0] position_next;
  logic last_of_run_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] rdata;
  logic hit;
  logic take_push;

  lss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(operand_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy = (state != IDLE);
  // shared comparator: current entry against the search key
  assign hit = (rdata == key);
  assign take_push = start && !busy && (mode == MODE_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos          <= pos_next;
    key          <= key_next;
    seek         <= seek_next;
    status       <= status_next;
    result_value <= result_value_next;
    position     <= position_next;
    last_of_run  <= last_of_run_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    pos_next          = pos;
    key_next          = key;
    seek_next         = seek;
    done_next         = 1'b0;
    status_next       = STAT_OK;
    result_value_next = '0;
    position_next     = '0;
    last_of_run_next  = 1'b1;
    we                = 1'b0;
    waddr             = AW'(count);
    raddr             = AW'(count - ONE);

    case (state)
      IDLE: begin
        if (start) begin
          key_next  = operand_value;
          seek_next = (mode == MODE_SEARCH);
          pos_next  = ONE;
          case (mode)
            MODE_PUSH: begin
              done_next = 1'b1;
              if (count == FULL) begin
                status_next = STAT_OVERFLOW;
              end else begin
                we                = 1'b1;
                count_next        = count + ONE;
                result_value_next = operand_value;
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = STAT_UNDERFLOW;
              end else begin
                count_next = count - ONE;
                state_next = POP_READ;
              end
            end
            MODE_SEARCH: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = STAT_NOT_FOUND;
              end else begin
                state_next = WALK;
              end
            end
            default: begin
              // display
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = STAT_EMPTY;
              end else begin
                state_next = WALK;
              end
            end
          endcase
        end
      end
      POP_READ: begin
        done_next         = 1'b1;
        result_value_next = rdata;
        state_next        = IDLE;
      end
      WALK: begin
        // fetch the entry one below the one now being checked
        raddr    = AW'(count - pos - ONE);
        pos_next = pos + ONE;
        if (seek) begin
          if (hit) begin
            done_next         = 1'b1;
            result_value_next = key;
            position_next     = POS_W'(pos);
            state_next        = IDLE;
          end else if (pos == count) begin
            done_next   = 1'b1;
            status_next = STAT_NOT_FOUND;
            state_next  = IDLE;
          end
        end else begin
          done_next         = 1'b1;
          result_value_next = rdata;
          position_next     = POS_W'(pos);
          last_of_run_next  = (pos == count);
          if (pos == count) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst || count <= FULL)
  `ASSERT_RST(a_push_grows, clk, rst, take_push && count != FULL |=> count == $past(count) + ONE)
  `ASSERT_RST(a_push_answers, clk, rst, take_push |=> done && last_of_run)
  `ASSERT_RST(a_run_continues, clk, rst, done && !last_of_run |-> busy)
  `ASSERT_RST(a_error_ends_run, clk, rst, done && status != STAT_OK |-> last_of_run)

endmodule
